@@ hdl/free_fly_camera_update_defines.svh @@
// Assertion macros shared by the camera block
`ifndef FREE_FLY_CAMERA_UPDATE_DEFINES_SVH
`define FREE_FLY_CAMERA_UPDATE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define FFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle
`define FFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ffc_pkg.sv @@
`default_nettype none
package ffc_pkg;

    localparam int DegQ16      = 65536;
    localparam int PitchLimit  = 89 * DegQ16;
    localparam int FullTurn    = 360 * DegQ16;
    localparam int HalfTurn    = 180 * DegQ16;
    localparam int QuarterTurn = 90 * DegQ16;
    localparam int CordicSteps = 17;
    localparam int CordicGain  = 652032875;
    localparam int OneQ14      = 16384;
    localparam int InvSqrt2Q14 = 11585;

    // register indexes
    localparam logic REG_MOVE_SPEED     = 1'b0;
    localparam logic REG_ROTATION_SPEED = 1'b1;

    typedef struct packed {
        logic        key_forward;
        logic        key_backward;
        logic        key_left;
        logic        key_right;
        logic signed [15:0] mouse_dx;
        logic signed [15:0] mouse_dy;
        logic [15:0] frame_time;
    } ffc_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } ffc_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE_K,
        ST_MOVE_AX,
        ST_ANGLE,
        ST_WRAP,
        ST_FOLD,
        ST_CORDIC,
        ST_AXES,
        ST_OUT
    } ffc_state_t;

    // arctangent table, Q.16 degrees
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0:    atan_deg = 22'd2949120;
            5'd1:    atan_deg = 22'd1740967;
            5'd2:    atan_deg = 22'd919879;
            5'd3:    atan_deg = 22'd466945;
            5'd4:    atan_deg = 22'd234379;
            5'd5:    atan_deg = 22'd117304;
            5'd6:    atan_deg = 22'd58666;
            5'd7:    atan_deg = 22'd29335;
            5'd8:    atan_deg = 22'd14668;
            5'd9:    atan_deg = 22'd7334;
            5'd10:   atan_deg = 22'd3667;
            5'd11:   atan_deg = 22'd1833;
            5'd12:   atan_deg = 22'd917;
            5'd13:   atan_deg = 22'd458;
            5'd14:   atan_deg = 22'd229;
            5'd15:   atan_deg = 22'd115;
            5'd16:   atan_deg = 22'd57;
            default: atan_deg = 22'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ hdl/ffc_stream_if.sv @@
`default_nettype none
interface ffc_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/ffc_serial_mul.sv @@
`default_nettype none
// Shift-add signed multiplier, one multiplier bit per cycle.
// Result is the signed product |a| * b with the sign of a applied; b is a magnitude.
module ffc_serial_mul (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [47:0]  a,
    input  wire logic [16:0]         b,
    output logic                     done,
    output logic signed [64:0]       p
);
    import ffc_pkg::*;

    logic [47:0] mcand_reg, mcand_next;
    logic [16:0] mplier_reg, mplier_next;
    logic [63:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [47:0] a_mag;

    assign a_mag = a[47] ? 48'(-a) : 48'(a);

    // one multiplier bit a cycle, LSB first, multiplicand shifts left
    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = a_mag;
            mplier_next = b;
            acc_next    = '0;
            cnt_next    = '0;
            busy_next   = 1'b1;
            neg_next    = a[47];
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + (64'(mcand_reg) << cnt_reg);
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
    end

    assign done = done_reg;
    assign p    = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
endmodule
`default_nettype wire

@@ hdl/ffc_cordic.sv @@
`default_nettype none
// Iterative CORDIC, one rotation step per cycle, 17 steps.
module ffc_cordic (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [31:0]  angle,
    output logic                     done,
    output logic signed [15:0]       sin_q14,
    output logic signed [15:0]       cos_q14
);
    import ffc_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic [4:0]  i_reg, i_next;
    logic        busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic signed [31:0] a1, a2;
    logic        fneg;
    logic signed [33:0] dx, dy, xo, yo;

    function automatic logic signed [15:0] rnd_clamp(input logic signed [33:0] v);
        logic [33:0] m;
        logic [33:0] r;
        logic signed [34:0] s;
        m = v[33] ? 34'(-v) : 34'(v);
        r = (m + 34'd32768) >> 16;
        s = v[33] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        if (s > 35'sd16384)
            rnd_clamp = 16'sd16384;
        else if (s < -35'sd16384)
            rnd_clamp = -16'sd16384;
        else
            rnd_clamp = 16'(s);
    endfunction

    // fold to [-90, 90]
    always_comb
    begin
        a1 = angle;
        if (a1 > 32'(HalfTurn))
            a1 = a1 - 32'(FullTurn);
        if (a1 < -32'(HalfTurn))
            a1 = a1 + 32'(FullTurn);
        a2   = a1;
        fneg = 1'b0;
        if (a1 > 32'(QuarterTurn))
        begin
            a2   = a1 - 32'(HalfTurn);
            fneg = 1'b1;
        end
        else if (a1 < -32'(QuarterTurn))
        begin
            a2   = a1 + 32'(HalfTurn);
            fneg = 1'b1;
        end
    end

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;

    // one rotation step a cycle
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = 34'(CordicGain);
            y_next    = '0;
            z_next    = a2;
            i_next    = '0;
            busy_next = 1'b1;
            neg_next  = fneg;
        end
        else if (busy_reg)
        begin
            if (!z_reg[31])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - 32'($signed({1'b0, atan_deg(i_reg)}));
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + 32'($signed({1'b0, atan_deg(i_reg)}));
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign xo      = neg_reg ? -x_reg : x_reg;
    assign yo      = neg_reg ? -y_reg : y_reg;
    assign done    = done_reg;
    assign cos_q14 = rnd_clamp(xo);
    assign sin_q14 = rnd_clamp(yo);
endmodule
`default_nettype wire

@@ hdl/free_fly_camera_update.sv @@
`default_nettype none
// Work per transaction: bit-serial multiplier products for the move and the angle
// updates, a serial restoring remainder on the yaw, two CORDIC runs (yaw, then pitch)
// and multiplier products for the axes; 12 products in all, 7 when the keys cancel.
// Throughput: one transaction at a time; the next is taken the cycle after the
// result has been taken. Reset clears state to the origin, facing +z, zero angles.
module free_fly_camera_update (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_we,
    input  wire logic    cfg_index,
    input  wire logic [15:0] cfg_data,
    ffc_stream_if.sink   in_ch,
    ffc_stream_if.source out_ch
);
    import ffc_pkg::*;
    `include "free_fly_camera_update_defines.svh"

    localparam int WrapSteps = 17;
    localparam logic [41:0] WrapDiv0 = 42'(FullTurn) << 16;

    ffc_state_t st_reg, st_next;
    ffc_in_t    in_reg;
    ffc_out_t   out_reg;
    logic [15:0] mspd_reg, rspd_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] fr_reg [3];
    logic signed [15:0] rt_reg [3];
    logic signed [31:0] yaw_reg, pitch_reg;
    logic signed [15:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic [1:0] ax_reg;       // axis / product index
    logic       ph_reg;       // which angle
    logic       mbusy_reg, cbusy_reg;
    logic signed [47:0] kval_reg, arg_a;
    logic [16:0] arg_b;
    logic signed [15:0] mval;
    logic signed [1:0] ka, kb;
    logic       mstart, mdone;
    logic signed [64:0] prod;
    logic       cstart, cdone;
    logic signed [31:0] cangle;
    logic signed [15:0] csin, ccos;
    logic signed [18:0] dir;
    logic signed [64:0] rnd36, rnd8, rnd14;
    logic signed [33:0] psum;
    logic signed [41:0] ang;
    logic        wneg_reg;
    logic [41:0] wrem_reg, wdiv_reg, wstep;
    logic [4:0]  wcnt_reg;

    function automatic logic signed [64:0] rshift(input logic signed [64:0] v,
                                                   input logic [5:0] s);
        logic [64:0] m;
        logic [64:0] r;
        m = v[64] ? 65'(-v) : 65'(v);
        r = (m + (65'd1 << (s - 6'd1))) >> s;
        rshift = v[64] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [15:0] clamp14(input logic signed [64:0] v);
        if (v > 65'sd16384)
            clamp14 = 16'sd16384;
        else if (v < -65'sd16384)
            clamp14 = -16'sd16384;
        else
            clamp14 = 16'(v);
    endfunction

    assign ka = $signed({1'b0, in_reg.key_forward}) - $signed({1'b0, in_reg.key_backward});
    assign kb = $signed({1'b0, in_reg.key_right}) - $signed({1'b0, in_reg.key_left});
    assign dir = 19'(ka) * 19'(fr_reg[ax_reg]) + 19'(kb) * 19'(rt_reg[ax_reg]);
    assign mval = (ax_reg == 2'd1) ? in_reg.mouse_dx : in_reg.mouse_dy;

    // multiplier operand select per state; signs move onto the multiplicand
    always_comb
    begin
        arg_a = '0;
        arg_b = '0;
        case (st_reg)
            ST_MOVE_K:
            begin
                // scale * speed first, then times dt (ax_reg 0 / 1)
                if (ax_reg == 2'd0)
                begin
                    arg_a = (ka != 2'sd0 && kb != 2'sd0) ? 48'(InvSqrt2Q14) : 48'(OneQ14);
                    arg_b = 17'(mspd_reg);
                end
                else
                begin
                    arg_a = kval_reg;
                    arg_b = 17'(in_reg.frame_time);
                end
            end
            ST_MOVE_AX:
            begin
                arg_a = dir[18] ? -kval_reg : kval_reg;
                arg_b = dir[18] ? 17'(-dir) : 17'(dir);
            end
            ST_ANGLE:
            begin
                // ax_reg 0: rate, 1: dx*rate, 2: dy*rate
                if (ax_reg == 2'd0)
                begin
                    arg_a = 48'(rspd_reg);
                    arg_b = 17'(in_reg.frame_time);
                end
                else
                begin
                    arg_a = mval[15] ? -kval_reg : kval_reg;
                    arg_b = mval[15] ? 17'(-$signed({mval[15], mval})) : 17'({1'b0, mval});
                end
            end
            ST_AXES:
            begin
                case (ax_reg)
                    2'd0:    arg_a = 48'(sy_reg);
                    2'd1:    arg_a = 48'(cy_reg);
                    2'd2:    arg_a = 48'(sy_reg);
                    default: arg_a = 48'(cy_reg);
                endcase
                arg_b = (ax_reg[1] ? (sp_reg[15] ? 17'(-sp_reg) : 17'(sp_reg))
                                   : (cp_reg[15] ? 17'(-cp_reg) : 17'(cp_reg)));
                if (ax_reg[1] ? sp_reg[15] : cp_reg[15])
                    arg_a = -arg_a;
            end
            default:
            begin
                arg_a = '0;
                arg_b = '0;
            end
        endcase
    end

    ffc_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .a     (arg_a),
        .b     (arg_b),
        .done  (mdone),
        .p     (prod)
    );

    ffc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cstart),
        .angle   (cangle),
        .done    (cdone),
        .sin_q14 (csin),
        .cos_q14 (ccos)
    );

    assign cangle = ph_reg ? pitch_reg : yaw_reg;
    assign cstart = (st_reg == ST_CORDIC) && !cbusy_reg;
    // no product when the keys cancel, the move is skipped
    assign mstart = (st_reg == ST_MOVE_K || st_reg == ST_MOVE_AX
                     || st_reg == ST_ANGLE || st_reg == ST_AXES) && !mbusy_reg
                    && !(st_reg == ST_MOVE_K && ka == 2'sd0 && kb == 2'sd0);

    assign rnd36 = rshift(prod, 6'd36);
    assign rnd8  = rshift(prod, 6'd8);
    assign rnd14 = rshift(prod, 6'd14);
    assign psum  = 34'(pos_reg[ax_reg]) + 34'(rnd36);
    assign ang   = (ax_reg == 2'd1) ? 42'(yaw_reg) + 42'(rnd8) : 42'(pitch_reg) - 42'(rnd8);
    // restoring remainder step on the yaw magnitude
    assign wstep = (wrem_reg >= wdiv_reg) ? wrem_reg - wdiv_reg : wrem_reg;

    assign in_ch.ready  = (st_reg == ST_IDLE);
    assign out_ch.valid = (st_reg == ST_OUT);
    assign out_ch.data  = out_reg;

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (in_ch.valid)
                    st_next = ST_MOVE_K;
            ST_MOVE_K:
                if (ka == 2'sd0 && kb == 2'sd0)
                    st_next = ST_ANGLE;
                else if (mdone && ax_reg == 2'd1)
                    st_next = ST_MOVE_AX;
            ST_MOVE_AX:
                if (mdone && ax_reg == 2'd2)
                    st_next = ST_ANGLE;
            ST_ANGLE:
                if (mdone && ax_reg == 2'd2)
                    st_next = ST_WRAP;
            ST_WRAP:
                if (wcnt_reg == 5'(WrapSteps - 1))
                    st_next = ST_CORDIC;
            ST_CORDIC:
                if (cdone && ph_reg)
                    st_next = ST_AXES;
            ST_AXES:
                if (mdone && ax_reg == 2'd3)
                    st_next = ST_OUT;
            ST_OUT:
                if (out_ch.ready)
                    st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            mspd_reg  <= 16'd2560;
            rspd_reg  <= 16'd256;
            pos_reg   <= '{32'sd0, 32'sd0, 32'sd0};
            fr_reg    <= '{16'sd0, 16'sd0, 16'(OneQ14)};
            rt_reg    <= '{16'(OneQ14), 16'sd0, 16'sd0};
            yaw_reg   <= '0;
            pitch_reg <= '0;
            sy_reg    <= '0;
            cy_reg    <= '0;
            sp_reg    <= '0;
            cp_reg    <= '0;
            kval_reg  <= '0;
            ax_reg    <= '0;
            ph_reg    <= 1'b0;
            mbusy_reg <= 1'b0;
            cbusy_reg <= 1'b0;
            wneg_reg  <= 1'b0;
            wrem_reg  <= '0;
            wdiv_reg  <= '0;
            wcnt_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we && st_reg == ST_IDLE)
            begin
                if (cfg_index == REG_MOVE_SPEED)
                    mspd_reg <= cfg_data;
                else
                    mspd_reg <= mspd_reg;
                if (cfg_index == REG_ROTATION_SPEED)
                    rspd_reg <= cfg_data;
            end
            if (mstart)
                mbusy_reg <= 1'b1;
            if (mdone)
                mbusy_reg <= 1'b0;
            if (cstart)
                cbusy_reg <= 1'b1;
            if (cdone)
                cbusy_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    ax_reg <= '0;
                    ph_reg <= 1'b0;
                end
                ST_MOVE_K:
                    if (ka == 2'sd0 && kb == 2'sd0)
                        ax_reg <= '0;
                    else if (mdone)
                    begin
                        kval_reg <= 48'(prod);
                        ax_reg   <= (ax_reg == 2'd1) ? 2'd0 : 2'd1;
                    end
                ST_MOVE_AX:
                    if (mdone)
                    begin
                        if (psum > 34'sd2147483647)
                            pos_reg[ax_reg] <= 32'sh7fffffff;
                        else if (psum < -34'sd2147483648)
                            pos_reg[ax_reg] <= 32'sh80000000;
                        else
                            pos_reg[ax_reg] <= 32'(psum);
                        ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                    end
                ST_ANGLE:
                    if (mdone)
                    begin
                        if (ax_reg == 2'd0)
                            kval_reg <= 48'(prod);
                        else if (ax_reg == 2'd1)
                        begin
                            // full-width yaw goes to the serial remainder
                            wneg_reg <= ang[41];
                            wrem_reg <= ang[41] ? 42'(-ang) : 42'(ang);
                            wdiv_reg <= WrapDiv0;
                            wcnt_reg <= '0;
                        end
                        else if (ang > 42'(PitchLimit))
                            pitch_reg <= 32'(PitchLimit);
                        else if (ang < -42'(PitchLimit))
                            pitch_reg <= -32'(PitchLimit);
                        else
                            pitch_reg <= 32'(ang);
                        ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                    end
                ST_WRAP:
                begin
                    // one subtract of 360 deg times 2^k per cycle, k from 16 down
                    wrem_reg <= wstep;
                    wdiv_reg <= wdiv_reg >> 1;
                    wcnt_reg <= wcnt_reg + 5'd1;
                    if (wcnt_reg == 5'(WrapSteps - 1))
                        yaw_reg <= wneg_reg ? -32'(wstep) : 32'(wstep);
                end
                ST_CORDIC:
                    if (cdone)
                    begin
                        if (!ph_reg)
                        begin
                            sy_reg <= csin;
                            cy_reg <= ccos;
                        end
                        else
                        begin
                            sp_reg <= csin;
                            cp_reg <= ccos;
                        end
                        ph_reg <= 1'b1;
                    end
                ST_AXES:
                    if (mdone)
                    begin
                        if (ax_reg == 2'd0)
                            fr_reg[0] <= clamp14(rnd14);
                        else if (ax_reg == 2'd1)
                            fr_reg[2] <= clamp14(rnd14);
                        ax_reg <= ax_reg + 2'd1;
                        if (ax_reg == 2'd3)
                        begin
                            fr_reg[1] <= sp_reg;
                            rt_reg    <= '{cy_reg, 16'sd0, 16'(-sy_reg)};
                        end
                    end
                default:
                    ax_reg <= ax_reg;
            endcase
        end
    end

    // input capture and result assembly
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            in_reg <= in_ch.data;
        if (st_reg == ST_AXES && mdone)
        begin
            if (ax_reg == 2'd2)
                out_reg.up_x <= clamp14(rnd14);
            if (ax_reg == 2'd3)
                out_reg.up_z <= clamp14(rnd14);
        end
        if (st_reg == ST_AXES && st_next == ST_OUT)
        begin
            out_reg.pos_x   <= pos_reg[0];
            out_reg.pos_y   <= pos_reg[1];
            out_reg.pos_z   <= pos_reg[2];
            out_reg.front_x <= fr_reg[0];
            out_reg.front_y <= sp_reg;
            out_reg.front_z <= fr_reg[2];
            out_reg.right_x <= cy_reg;
            out_reg.right_y <= 16'sd0;
            out_reg.right_z <= 16'(-sy_reg);
            out_reg.up_y    <= 16'(-cp_reg);
        end
    end

    `FFC_ASSERT_IMP(a_ready_idle, in_ch.ready, out_ch.valid == 1'b0, "ready while result pending")
    `FFC_ASSERT_IMP(a_pitch_lim, 1'b1, pitch_reg <= 32'(PitchLimit) && pitch_reg >= -32'(PitchLimit), "pitch out of range")
    `FFC_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
    `FFC_ASSERT_IMP(a_one_unit, mstart, !cstart, "units started together")
endmodule
`default_nettype wire
